// ===== design/bmr_pkg.sv =====
// shared constants, types and helpers for the bitmap rotation core
`default_nettype none
package bmr_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int FRAC_BITS   = 14;
  localparam int SHIFT       = FRAC_BITS + 1;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int SIZE_W     = 8;
  localparam int COEF_W     = 16;
  localparam int COLOR_W    = 24;
  localparam int OFF_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // operand, product and sum widths of the coordinate arithmetic
  localparam int D_W    = 12;
  localparam int PROD_W = COEF_W + D_W;
  localparam int BASE_W = SIZE_W + FRAC_BITS;
  localparam int SUM_W  = ((BASE_W > PROD_W) ? BASE_W : PROD_W) + 2;
  localparam int CO_W   = SUM_W - SHIFT;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_ANGLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_ANGLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR = 3'd4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef struct packed {
    logic load;
    logic sel_box;
    logic mul_en;
    logic box_latch;
    logic map_sum;
    logic addr_en;
    logic read_en;
    logic out_load;
  } bmr_cmd_t;

  typedef struct packed {
    logic origin;
    logic out_free;
  } bmr_stat_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (int'(v) > maxv) begin
      r = SIZE_W'(maxv);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/bmr_if.sv =====
// input and result channel interfaces of the bitmap rotation core
`default_nettype none
interface bmr_in_if;
  import bmr_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [COLOR_W-1:0] pixel;

  modport source (output valid, output cmd, output pixel, input ready);
  modport sink (input valid, input cmd, input pixel, output ready);
endinterface

interface bmr_out_if;
  import bmr_pkg::*;
  logic               valid;
  logic               ready;
  logic [SIZE_W-1:0]  dst_x;
  logic [SIZE_W-1:0]  dst_y;
  logic [COLOR_W-1:0] color;
  logic               from_source;
  logic [SIZE_W-1:0]  out_width;
  logic [SIZE_W-1:0]  out_height;
  logic               last;

  modport source (output valid, output dst_x, output dst_y, output color,
                  output from_source, output out_width, output out_height,
                  output last, input ready);
  modport sink (input valid, input dst_x, input dst_y, input color,
                input from_source, input out_width, input out_height,
                input last, output ready);
endinterface
`default_nettype wire

// ===== design/bitmap_rotate_nearest_core.sv =====
// loads are taken one per cycle while idle and write the single-port image store
// an emit runs the map multiply, map sum, address, read and output states, the
// first pixel of a frame after box multiply and box sum latch the bounding box;
// output waits while the result is not taken; input reopens as the result shows
// reset is synchronous and clears control state; the image store is not cleared
`default_nettype none
module bitmap_rotate_nearest_core (
  input  logic                            clk,
  input  logic                            rst_n,
  bmr_in_if.sink                          in_ch,
  bmr_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [bmr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bmr_pkg::*;

  bmr_cmd_t  ctl;
  bmr_stat_t stat;

  bmr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .stat  (stat),
    .ctl   (ctl)
  );

  bmr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (in_ch.pixel),
    .ctl       (ctl),
    .stat      (stat),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // a load transaction never produces a result
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_LOAD) && !out_ch.valid)
      |=> !out_ch.valid)
    else $error("load transaction raised a result");

  // an emit transaction holds off further input while it is worked on
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_EMIT)) |=> !in_ch.ready)
    else $error("input accepted during emit");

  // the final pixel sits in the last column of the box
  a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last)
      |-> (({1'b0, out_ch.dst_x} + 9'd1) == {1'b0, out_ch.out_width}))
    else $error("last flag off the final column");
`endif

endmodule
`default_nettype wire

// ===== design/bmr_ctrl.sv =====
// sequencing state machine of the bitmap rotation core
`default_nettype none
module bmr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  bmr_in_if.sink              in_ch,
  input  bmr_pkg::bmr_stat_t  stat,
  output bmr_pkg::bmr_cmd_t   ctl
);
  import bmr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_BOX_MUL = 8'b0000_0010,
    S_BOX_SUM = 8'b0000_0100,
    S_MAP_MUL = 8'b0000_1000,
    S_MAP_SUM = 8'b0001_0000,
    S_ADDR    = 8'b0010_0000,
    S_READ    = 8'b0100_0000,
    S_OUT     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.cmd == CMD_LOAD) begin
            ctl.load = 1'b1;
          end else begin
            // first pixel of a frame latches the bounding box first
            state_nxt = stat.origin ? S_BOX_MUL : S_MAP_MUL;
          end
        end
      end
      S_BOX_MUL: begin
        ctl.sel_box = 1'b1;
        ctl.mul_en  = 1'b1;
        state_nxt   = S_BOX_SUM;
      end
      S_BOX_SUM: begin
        ctl.box_latch = 1'b1;
        state_nxt     = S_MAP_MUL;
      end
      S_MAP_MUL: begin
        ctl.mul_en = 1'b1;
        state_nxt  = S_MAP_SUM;
      end
      S_MAP_SUM: begin
        ctl.map_sum = 1'b1;
        state_nxt   = S_ADDR;
      end
      S_ADDR: begin
        ctl.addr_en = 1'b1;
        state_nxt   = S_READ;
      end
      S_READ: begin
        ctl.read_en = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/bmr_datapath.sv =====
// registers, image store and coordinate arithmetic of the bitmap rotation core
`default_nettype none
module bmr_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bmr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [bmr_pkg::COLOR_W-1:0]        pixel,
  input  bmr_pkg::bmr_cmd_t                  ctl,
  output bmr_pkg::bmr_stat_t                 stat,
  bmr_out_if.source                          out_ch
);
  import bmr_pkg::*;

  localparam logic signed [SUM_W-1:0] LIM_ZERO = 0;
  localparam logic signed [SUM_W-1:0] LIM_ONE  = 1;
  localparam logic signed [SUM_W-1:0] LIM_255  = 255;
  localparam logic signed [SUM_W-1:0] LIM_M256 = -256;
  localparam logic signed [SUM_W-1:0] RND_C    = SUM_W'((64'd1 << SHIFT) - 64'd1);

  // configuration
  logic        [SIZE_W-1:0]  w_reg_r, h_reg_r;
  logic signed [COEF_W-1:0]  cos_r, sin_r;
  logic        [COLOR_W-1:0] fill_r;

  // frame state
  logic        [ADDR_W-1:0]  load_idx_r, load_idx_nxt;
  logic        [SIZE_W-1:0]  col_r, row_r, col_nxt, row_nxt;
  logic signed [OFF_W-1:0]   off_x_r, off_y_r, off_x_nxt, off_y_nxt;
  logic        [SIZE_W-1:0]  bw_r, bh_r, bw_nxt, bh_nxt;

  // arithmetic pipeline
  logic signed [PROD_W-1:0]  p_ca_r, p_sb_r, p_sa_r, p_cb_r;
  logic signed [CO_W-1:0]    sx_r, sy_r, sx_nxt, sy_nxt;
  logic        [ADDR_W-1:0]  addr_r, addr_nxt;
  logic                      inside_r, inside_nxt;
  logic        [COLOR_W-1:0] rdata_r;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  logic        [SIZE_W-1:0]  o_x_r, o_y_r, o_w_r, o_h_r;
  logic        [COLOR_W-1:0] o_color_r;
  logic                      o_src_r, o_last_r;

  logic [COLOR_W-1:0] image_store [STORE_DEPTH];

  logic        [SIZE_W-1:0]   w_use, h_use;
  logic        [2*SIZE_W-1:0] img_size, lin_addr;
  logic        [ADDR_W-1:0]   wr_idx;
  logic        [ADDR_W:0]     wr_inc;
  logic signed [D_W-1:0]      w_ext, h_ext, pos_x, pos_y, dx, dy, mul_a, mul_b;
  logic signed [SUM_W-1:0]    base_x, base_y, ext_ca, ext_sb, ext_sa, ext_cb;
  logic signed [SUM_W-1:0]    abs_ca, abs_sb, abs_sa, abs_cb;
  logic signed [SUM_W-1:0]    minx, maxx, miny, maxy, ox, oy, hx, hy, bwid, bhgt;
  logic signed [SUM_W-1:0]    vx, vy, rvx, rvy, tx, ty;
  logic        [SIZE_W:0]     col_inc, row_inc;
  logic                       last_flag;

  assign w_use    = clamp_size(w_reg_r, MAX_WIDTH);
  assign h_use    = clamp_size(h_reg_r, MAX_HEIGHT);
  assign img_size = {{SIZE_W{1'b0}}, w_use} * {{SIZE_W{1'b0}}, h_use};

  // load pointer: an out-of-range pointer restarts at zero before the write
  always_comb begin
    wr_idx       = (32'(load_idx_r) >= 32'(img_size)) ? '0 : load_idx_r;
    wr_inc       = {1'b0, wr_idx} + (ADDR_W + 1)'(1);
    load_idx_nxt = (32'(wr_inc) >= 32'(img_size)) ? '0 : wr_inc[ADDR_W-1:0];
  end

  // multiplier operands
  always_comb begin
    w_ext = $signed({{(D_W - SIZE_W){1'b0}}, w_use});
    h_ext = $signed({{(D_W - SIZE_W){1'b0}}, h_use});
    pos_x = $signed({{(D_W - SIZE_W){1'b0}}, col_r}) + D_W'(off_x_r);
    pos_y = $signed({{(D_W - SIZE_W){1'b0}}, row_r}) + D_W'(off_y_r);
    dx    = (pos_x <<< 1) - w_ext;
    dy    = (pos_y <<< 1) - h_ext;
    mul_a = ctl.sel_box ? w_ext : dx;
    mul_b = ctl.sel_box ? h_ext : dy;
  end

  // bounding box: the corner extremes are the centre plus or minus both magnitudes
  always_comb begin
    base_x = $signed({{(SUM_W - BASE_W){1'b0}}, w_use, {FRAC_BITS{1'b0}}});
    base_y = $signed({{(SUM_W - BASE_W){1'b0}}, h_use, {FRAC_BITS{1'b0}}});
    ext_ca = SUM_W'(p_ca_r);
    ext_sb = SUM_W'(p_sb_r);
    ext_sa = SUM_W'(p_sa_r);
    ext_cb = SUM_W'(p_cb_r);
    abs_ca = ext_ca[SUM_W-1] ? -ext_ca : ext_ca;
    abs_sb = ext_sb[SUM_W-1] ? -ext_sb : ext_sb;
    abs_sa = ext_sa[SUM_W-1] ? -ext_sa : ext_sa;
    abs_cb = ext_cb[SUM_W-1] ? -ext_cb : ext_cb;
    minx   = base_x - abs_ca - abs_sb;
    maxx   = base_x + abs_ca + abs_sb;
    miny   = base_y - abs_cb - abs_sa;
    maxy   = base_y + abs_cb + abs_sa;
    ox     = minx >>> SHIFT;
    oy     = miny >>> SHIFT;
    hx     = (maxx + RND_C) >>> SHIFT;
    hy     = (maxy + RND_C) >>> SHIFT;
    bwid   = hx - ox;
    bhgt   = hy - oy;

    bw_nxt = (bwid < LIM_ONE) ? SIZE_W'(1) :
             (bwid > LIM_255) ? SIZE_W'(255) : bwid[SIZE_W-1:0];
    bh_nxt = (bhgt < LIM_ONE) ? SIZE_W'(1) :
             (bhgt > LIM_255) ? SIZE_W'(255) : bhgt[SIZE_W-1:0];
    off_x_nxt = (ox < LIM_M256) ? OFF_W'(-256) :
                (ox > LIM_255)  ? OFF_W'(255)  : ox[OFF_W-1:0];
    off_y_nxt = (oy < LIM_M256) ? OFF_W'(-256) :
                (oy > LIM_255)  ? OFF_W'(255)  : oy[OFF_W-1:0];
  end

  // inverse mapping, truncated toward zero
  always_comb begin
    vx     = base_x + ext_ca - ext_sb;
    vy     = base_y + ext_sa + ext_cb;
    rvx    = vx + (vx[SUM_W-1] ? RND_C : LIM_ZERO);
    rvy    = vy + (vy[SUM_W-1] ? RND_C : LIM_ZERO);
    tx     = rvx >>> SHIFT;
    ty     = rvy >>> SHIFT;
    sx_nxt = tx[CO_W-1:0];
    sy_nxt = ty[CO_W-1:0];
  end

  always_comb begin
    inside_nxt = !sx_r[CO_W-1] && !sy_r[CO_W-1] &&
                 (sx_r < $signed(CO_W'(w_use))) && (sy_r < $signed(CO_W'(h_use)));
    lin_addr   = {{SIZE_W{1'b0}}, sy_r[SIZE_W-1:0]} * {{SIZE_W{1'b0}}, w_use} +
                 {{SIZE_W{1'b0}}, sx_r[SIZE_W-1:0]};
    addr_nxt   = ADDR_W'(lin_addr);
  end

  // raster scan over the latched box
  always_comb begin
    col_inc   = {1'b0, col_r} + (SIZE_W + 1)'(1);
    row_inc   = {1'b0, row_r} + (SIZE_W + 1)'(1);
    last_flag = (col_inc == {1'b0, bw_r}) && (row_inc == {1'b0, bh_r});
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (col_inc >= {1'b0, bw_r}) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, bh_r}) ? '0 : row_inc[SIZE_W-1:0];
    end else begin
      col_nxt = col_inc[SIZE_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign stat.origin   = (col_r == '0) && (row_r == '0);
  assign stat.out_free = !out_valid_r || out_ch.ready;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_reg_r     <= SIZE_W'(128);
      h_reg_r     <= SIZE_W'(128);
      cos_r       <= COEF_W'(16384);
      sin_r       <= '0;
      fill_r      <= '0;
      load_idx_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      off_x_r     <= '0;
      off_y_r     <= '0;
      bw_r        <= '0;
      bh_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_WIDTH:  w_reg_r <= cfg_data[SIZE_W-1:0];
          CFG_SRC_HEIGHT: h_reg_r <= cfg_data[SIZE_W-1:0];
          CFG_COS_ANGLE:  cos_r   <= cfg_data[COEF_W-1:0];
          CFG_SIN_ANGLE:  sin_r   <= cfg_data[COEF_W-1:0];
          CFG_FILL_COLOR: fill_r  <= cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (ctl.load) begin
        load_idx_r <= load_idx_nxt;
      end
      if (ctl.box_latch) begin
        off_x_r <= off_x_nxt;
        off_y_r <= off_y_nxt;
        bw_r    <= bw_nxt;
        bh_r    <= bh_nxt;
      end
      if (ctl.out_load) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      p_ca_r <= PROD_W'(cos_r) * PROD_W'(mul_a);
      p_sb_r <= PROD_W'(sin_r) * PROD_W'(mul_b);
      p_sa_r <= PROD_W'(sin_r) * PROD_W'(mul_a);
      p_cb_r <= PROD_W'(cos_r) * PROD_W'(mul_b);
    end
    if (ctl.map_sum) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
    end
    if (ctl.addr_en) begin
      addr_r   <= addr_nxt;
      inside_r <= inside_nxt;
    end
    if (ctl.out_load) begin
      o_x_r     <= col_r;
      o_y_r     <= row_r;
      o_color_r <= inside_r ? rdata_r : fill_r;
      o_src_r   <= inside_r;
      o_w_r     <= bw_r;
      o_h_r     <= bh_r;
      o_last_r  <= last_flag;
    end
  end

  // image store
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      image_store[wr_idx] <= pixel;
    end
    if (ctl.read_en) begin
      rdata_r <= image_store[addr_r];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.dst_x       = o_x_r;
  assign out_ch.dst_y       = o_y_r;
  assign out_ch.color       = o_color_r;
  assign out_ch.from_source = o_src_r;
  assign out_ch.out_width   = o_w_r;
  assign out_ch.out_height  = o_h_r;
  assign out_ch.last        = o_last_r;

endmodule
`default_nettype wire

// ===== bench/bitmap_rotate_nearest_core_tb.sv =====
// self-checking testbench for the nearest-neighbour bitmap rotation core
module bitmap_rotate_nearest_core_tb;
  import bmr_pkg::*;

  localparam int ITEM_TARGET    = 1050;
  localparam int BUSY_IDLE_PCT  = 82;
  localparam int LIGHT_IDLE_PCT = 11;
  localparam int SETTLE_CYCLES  = 12;
  localparam int PRINT_CAP      = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [SIZE_W-1:0]  dst_x;
    logic [SIZE_W-1:0]  dst_y;
    logic [COLOR_W-1:0] color;
    logic               from_source;
    logic [SIZE_W-1:0]  out_width;
    logic [SIZE_W-1:0]  out_height;
    logic               last;
  } dst_pixel_t;

  localparam dst_pixel_t NO_RESULT = '0;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_EMIT} row_kind_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [COLOR_W-1:0]     data;
    logic                   typed;
    dst_pixel_t             res;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bmr_in_if  in_if ();
  bmr_out_if out_if ();

  bitmap_rotate_nearest_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow registers and rotation state
  logic [SIZE_W-1:0]  sh_w = 8'd128;
  logic [SIZE_W-1:0]  sh_h = 8'd128;
  logic [COEF_W-1:0]  sh_cos = 16'd16384;
  logic [COEF_W-1:0]  sh_sin = 16'd0;
  logic [COLOR_W-1:0] sh_fill = '0;
  logic [COLOR_W-1:0] image_copy [STORE_DEPTH];
  longint             ld_idx = 0;
  longint             scan_x = 0;
  longint             scan_y = 0;
  longint             box_w = 0;
  longint             box_h = 0;
  longint             box_ox = 0;
  longint             box_oy = 0;

  dst_pixel_t pending_pixels [$];
  int         fail_count = 0;
  int         items_sent = 0;
  int         send_idle_pct = 0;
  int         rcv_stall_pct = 0;

  stim_row_t directed_rows [24] = '{
    '{ROW_CFG,  CFG_SRC_WIDTH,  24'd2,        1'b0, NO_RESULT},
    '{ROW_CFG,  CFG_SRC_HEIGHT, 24'd2,        1'b0, NO_RESULT},
    '{ROW_CFG,  CFG_COS_ANGLE,  24'd16384,    1'b0, NO_RESULT},
    '{ROW_CFG,  CFG_SIN_ANGLE,  24'd0,        1'b0, NO_RESULT},
    '{ROW_CFG,  CFG_FILL_COLOR, 24'hFFFFFF,   1'b0, NO_RESULT},
    '{ROW_LOAD, '0,             24'h000000,   1'b0, NO_RESULT},
    '{ROW_LOAD, '0,             24'hFFFFFF,   1'b0, NO_RESULT},
    '{ROW_LOAD, '0,             24'h123456,   1'b0, NO_RESULT},
    '{ROW_LOAD, '0,             24'hABCDEF,   1'b0, NO_RESULT},
    // identity on a 2x2 image is a straight copy
    '{ROW_EMIT, '0, 24'h0, 1'b1, '{8'd0, 8'd0, 24'h000000, 1'b1, 8'd2, 8'd2, 1'b0}},
    '{ROW_EMIT, '0, 24'h0, 1'b1, '{8'd1, 8'd0, 24'hFFFFFF, 1'b1, 8'd2, 8'd2, 1'b0}},
    '{ROW_EMIT, '0, 24'h0, 1'b1, '{8'd0, 8'd1, 24'h123456, 1'b1, 8'd2, 8'd2, 1'b0}},
    '{ROW_EMIT, '0, 24'h0, 1'b1, '{8'd1, 8'd1, 24'hABCDEF, 1'b1, 8'd2, 8'd2, 1'b1}},
    // half turn: cosine of minus one
    '{ROW_CFG,  CFG_COS_ANGLE,  24'h00C000,   1'b0, NO_RESULT},
    '{ROW_EMIT, '0,             24'h000000,   1'b0, NO_RESULT},
    '{ROW_EMIT, '0,             24'hFFFFFF,   1'b0, NO_RESULT},
    '{ROW_EMIT, '0,             24'h000000,   1'b0, NO_RESULT},
    '{ROW_EMIT, '0,             24'hFFFFFF,   1'b0, NO_RESULT},
    '{ROW_CFG,  CFG_UNUSED,     24'hFFFFFF,   1'b0, NO_RESULT},
    // zero sizes clamp to a single pixel
    '{ROW_CFG,  CFG_SRC_WIDTH,  24'd0,        1'b0, NO_RESULT},
    '{ROW_CFG,  CFG_SRC_HEIGHT, 24'd0,        1'b0, NO_RESULT},
    '{ROW_CFG,  CFG_COS_ANGLE,  24'd16384,    1'b0, NO_RESULT},
    '{ROW_LOAD, '0,             24'h5A5A5A,   1'b0, NO_RESULT},
    '{ROW_EMIT, '0, 24'h0, 1'b1, '{8'd0, 8'd0, 24'h5A5A5A, 1'b1, 8'd1, 8'd1, 1'b1}}
  };

  function automatic longint eff_size(logic [SIZE_W-1:0] v, int maxv);
    if (v == '0) return 1;
    if (int'(v) > maxv) return maxv;
    return longint'(v);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint floor_sh(longint v);
    if (v >= 0) return v >>> SHIFT;
    return -((-v + (longint'(1) <<< SHIFT) - 1) >>> SHIFT);
  endfunction

  function automatic longint trunc_sh(longint v);
    if (v >= 0) return v >>> SHIFT;
    return -((-v) >>> SHIFT);
  endfunction

  // advances the rotation state by one transaction and gives the pixel it yields
  task automatic rotate_pixel(input logic cmd, input logic [COLOR_W-1:0] pixel,
                              output bit has_res, output dst_pixel_t res);
    longint w, h, c, s, one, ex, ey, vx, vy;
    longint minx, maxx, miny, maxy, ox, oy, dx, dy, sx, sy;
    bit     in_src;
    w = eff_size(sh_w, MAX_WIDTH);
    h = eff_size(sh_h, MAX_HEIGHT);
    c = longint'($signed(sh_cos));
    s = longint'($signed(sh_sin));
    one = longint'(1) <<< FRAC_BITS;
    minx = 0; maxx = 0; miny = 0; maxy = 0;
    has_res = 1'b0;
    res = NO_RESULT;
    if (cmd == CMD_LOAD) begin
      if (ld_idx >= w * h) ld_idx = 0;
      image_copy[ld_idx] = pixel;
      ld_idx++;
      if (ld_idx >= w * h) ld_idx = 0;
    end else begin
      if (scan_x == 0 && scan_y == 0) begin
        // bounding box of the four rotated corners, in doubled coordinates
        for (int i = 0; i < 4; i++) begin
          ex = (i == 1 || i == 2) ? w : -w;
          ey = (i >= 2) ? h : -h;
          vx = w * one + ex * c - ey * s;
          vy = h * one + ey * c + ex * s;
          if (i == 0 || vx < minx) minx = vx;
          if (i == 0 || vx > maxx) maxx = vx;
          if (i == 0 || vy < miny) miny = vy;
          if (i == 0 || vy > maxy) maxy = vy;
        end
        ox = floor_sh(minx);
        oy = floor_sh(miny);
        box_w = clip(-floor_sh(-maxx) - ox, 1, 255);
        box_h = clip(-floor_sh(-maxy) - oy, 1, 255);
        box_ox = clip(ox, -256, 255);
        box_oy = clip(oy, -256, 255);
      end
      dx = 2 * (scan_x + box_ox) - w;
      dy = 2 * (scan_y + box_oy) - h;
      sx = trunc_sh(w * one + c * dx - s * dy);
      sy = trunc_sh(h * one + s * dx + c * dy);
      in_src = (sx >= 0) && (sy >= 0) && (sx < w) && (sy < h);
      res.dst_x = scan_x[SIZE_W-1:0];
      res.dst_y = scan_y[SIZE_W-1:0];
      res.color = in_src ? image_copy[(sy * w + sx) % STORE_DEPTH] : sh_fill;
      res.from_source = in_src;
      res.out_width = box_w[SIZE_W-1:0];
      res.out_height = box_h[SIZE_W-1:0];
      res.last = (scan_x + 1 == box_w) && (scan_y + 1 == box_h);
      has_res = 1'b1;
      scan_x++;
      if (scan_x >= box_w) begin
        scan_x = 0;
        scan_y++;
        if (scan_y >= box_h) scan_y = 0;
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    end
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_item(input logic cmd, input logic [COLOR_W-1:0] pixel,
                            input bit typed, input dst_pixel_t typed_res);
    bit         has_res;
    dst_pixel_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd   <= cmd;
    in_if.pixel <= pixel;
    do @(posedge clk); while (!in_if.ready);
    rotate_pixel(cmd, pixel, has_res, res);
    if (has_res) pending_pixels = {pending_pixels, (typed ? typed_res : res)};
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    // a load transaction may still be writing the store
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:  sh_w = data[SIZE_W-1:0];
      CFG_SRC_HEIGHT: sh_h = data[SIZE_W-1:0];
      CFG_COS_ANGLE:  sh_cos = data[COEF_W-1:0];
      CFG_SIN_ANGLE:  sh_sin = data[COEF_W-1:0];
      CFG_FILL_COLOR: sh_fill = data[COLOR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    dst_pixel_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel with nothing pending, dst_x", 32'(out_if.dst_x), 32'd0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_if.dst_x !== want.dst_x) begin
          report_mismatch("dst_x", 32'(out_if.dst_x), 32'(want.dst_x));
        end
        if (out_if.dst_y !== want.dst_y) begin
          report_mismatch("dst_y", 32'(out_if.dst_y), 32'(want.dst_y));
        end
        if (out_if.color !== want.color) begin
          report_mismatch("color", 32'(out_if.color), 32'(want.color));
        end
        if (out_if.from_source !== want.from_source) begin
          report_mismatch("from_source", 32'(out_if.from_source), 32'(want.from_source));
        end
        if (out_if.out_width !== want.out_width) begin
          report_mismatch("out_width", 32'(out_if.out_width), 32'(want.out_width));
        end
        if (out_if.out_height !== want.out_height) begin
          report_mismatch("out_height", 32'(out_if.out_height), 32'(want.out_height));
        end
        if (out_if.last !== want.last) begin
          report_mismatch("last", 32'(out_if.last), 32'(want.last));
        end
      end
    end
  end

  initial begin
    int         phase_no;
    int         n;
    int         pick;
    int         cs;
    int         sn;
    logic [7:0] wv;
    logic [7:0] hv;
    bit         extreme;
    bit         frame_done;
    longint     sz;
    idle_mode_t mode;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_if.valid = 1'b0;
    in_if.cmd   = CMD_LOAD;
    in_if.pixel = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          wait_drained();
          write_reg(directed_rows[i].idx, directed_rows[i].data);
        end
        ROW_LOAD: drive_item(CMD_LOAD, directed_rows[i].data, 1'b0, NO_RESULT);
        default: drive_item(CMD_EMIT, directed_rows[i].data, directed_rows[i].typed,
                            directed_rows[i].res);
      endcase
    end

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      mode = idle_mode_t'(phase_no % 4);
      extreme = (phase_no < 2);
      // wide or tall images only start on a frame boundary so their box stays small
      if (extreme) begin
        while (!(scan_x == 0 && scan_y == 0)) begin
          drive_item(CMD_EMIT, COLOR_W'($urandom()), 1'b0, NO_RESULT);
        end
      end
      wait_drained();
      case (mode)
        IDLE_NONE:     begin send_idle_pct = 0;              rcv_stall_pct = 0;              end
        IDLE_SENDER:   begin send_idle_pct = BUSY_IDLE_PCT;  rcv_stall_pct = 0;              end
        IDLE_RECEIVER: begin send_idle_pct = 0;              rcv_stall_pct = BUSY_IDLE_PCT;  end
        default:       begin send_idle_pct = LIGHT_IDLE_PCT; rcv_stall_pct = LIGHT_IDLE_PCT; end
      endcase

      if (extreme) begin
        if (phase_no == 0) begin
          wv = $urandom_range(1) ? 8'd128 : 8'd255;
          hv = 8'd1;
        end else begin
          wv = $urandom_range(1) ? 8'd1 : 8'd0;
          hv = $urandom_range(1) ? 8'd128 : 8'd200;
        end
        cs = $urandom_range(1) ? 16384 : -16384;
        sn = 0;
      end else begin
        wv = 8'($urandom_range(0, 8));
        hv = 8'($urandom_range(0, 8));
        if ($urandom_range(9) == 0) wv = 8'($urandom_range(9, 12));
        if ($urandom_range(9) == 0) hv = 8'($urandom_range(9, 12));
        pick = $urandom_range(0, 7);
        case (pick)
          0: begin cs = 16384;  sn = 0;      end
          1: begin cs = 0;      sn = 16384;  end
          2: begin cs = -16384; sn = 0;      end
          3: begin cs = 0;      sn = -16384; end
          4: begin cs = 0;      sn = 0;      end
          5: begin
            cs = $urandom_range(1) ? 16384 : -16384;
            sn = $urandom_range(1) ? 16384 : -16384;
          end
          default: begin
            cs = int'($urandom_range(0, 32768)) - 16384;
            sn = int'($urandom_range(0, 32768)) - 16384;
          end
        endcase
      end
      write_reg(CFG_SRC_WIDTH, {16'h0, wv});
      write_reg(CFG_SRC_HEIGHT, {16'h0, hv});
      write_reg(CFG_COS_ANGLE, {8'h0, 16'(cs)});
      write_reg(CFG_SIN_ANGLE, {8'h0, 16'(sn)});
      write_reg(CFG_FILL_COLOR, CFG_DATA_W'($urandom()));

      // every entry the new size can address is written before any emit
      sz = eff_size(wv, MAX_WIDTH) * eff_size(hv, MAX_HEIGHT);
      for (longint k = 0; k < sz; k++) begin
        drive_item(CMD_LOAD, COLOR_W'($urandom()), 1'b0, NO_RESULT);
      end

      if (extreme) begin
        frame_done = 1'b0;
        while (!frame_done) begin
          if ($urandom_range(99) < 15) begin
            drive_item(CMD_LOAD, COLOR_W'($urandom()), 1'b0, NO_RESULT);
          end else begin
            drive_item(CMD_EMIT, COLOR_W'($urandom()), 1'b0, NO_RESULT);
            frame_done = (scan_x == 0 && scan_y == 0);
          end
        end
      end else begin
        n = $urandom_range(20, 90);
        repeat (n) begin
          drive_item(($urandom_range(99) < 75) ? CMD_EMIT : CMD_LOAD, COLOR_W'($urandom()),
                     1'b0, NO_RESULT);
        end
      end
      phase_no++;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== bitmap_rotate_nearest_core.f =====
design/bmr_pkg.sv
design/bmr_if.sv
design/bmr_ctrl.sv
design/bmr_datapath.sv
design/bitmap_rotate_nearest_core.sv
bench/bitmap_rotate_nearest_core_tb.sv
